// ===== rtl/hsvrgbw_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgbw_pkg
// Shared types, constants and arithmetic helpers for the HSV to RGBW
// color converter.
// ----------------------------------------------------------------------------
package hsvrgbw_pkg;

    // Number of hue steps on the hexcone and the width of one segment.
    localparam logic [10:0] HEX_STEPS  = 11'd1530;
    localparam logic [10:0] SEG_W      = 11'd255;
    localparam logic [10:0] SEG_2      = 11'd510;
    localparam logic [10:0] SEG_3      = 11'd765;
    localparam logic [10:0] SEG_4      = 11'd1020;
    localparam logic [10:0] SEG_5      = 11'd1275;

    // Rounding offset for the hue scaling (one half of the 2^16 divisor).
    localparam logic [26:0] HUE_ROUND  = 27'd32768;

    localparam logic [7:0]  CHAN_FULL  = 8'd255;
    localparam logic [7:0]  CHAN_ZERO  = 8'd0;

    // Payload after the hue has been mapped onto the hexcone step.
    typedef struct packed {
        logic [10:0] step;
        logic [7:0]  saturation;
        logic [7:0]  value;
        logic [7:0]  white;
    } hue_step_t;

    // Pure primaries before saturation and value scaling.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] saturation;
        logic [7:0] value;
        logic [7:0] white;
    } rgb_pure_t;

    // Channels after saturation scaling, waiting for value scaling.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] value;
        logic [7:0] white;
    } rgb_sat_t;

    // Computes (a * (b + 1)) >> 8. The result never exceeds a.
    function automatic logic [7:0] mul_frac(input logic [7:0] a, input logic [7:0] b);
        logic [16:0] prod;
        prod = 17'(a) * (17'(b) + 17'd1);
        return prod[15:8];
    endfunction

endpackage

// ===== rtl/hsvrgbw_in_if.sv =====
// ----------------------------------------------------------------------------
// hsvrgbw_in_if
// HSV plus white request channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hsvrgbw_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  value;
    logic [7:0]  white_level;

    modport source (output valid, output hue, output saturation, output value,
                    output white_level, input ready);
    modport sink   (input valid, input hue, input saturation, input value,
                    input white_level, output ready);
endinterface

// ===== rtl/hsvrgbw_out_if.sv =====
// ----------------------------------------------------------------------------
// hsvrgbw_out_if
// RGBW result channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hsvrgbw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;

    modport source (output valid, output red, output green, output blue,
                    output white, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input white, output ready);
endinterface

// ===== rtl/hsvrgbw_hue_stage.sv =====
// ----------------------------------------------------------------------------
// hsvrgbw_hue_stage
// First two pipeline stages: rounds the 16-bit hue onto the 1530-step
// hexcone, then selects the pure primary ramps of its segment.
// ----------------------------------------------------------------------------
module hsvrgbw_hue_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    hsvrgbw_in_if.sink             in_ch,
    output logic                   mid_valid,
    input  logic                   mid_ready,
    output hsvrgbw_pkg::rgb_pure_t mid_data
);
    import hsvrgbw_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    hue_step_t   s1_data_reg;
    hue_step_t   s1_data_next;
    logic        s1_ready;

    logic        s2_valid_reg;
    logic        s2_valid_next;
    rgb_pure_t   s2_data_reg;
    rgb_pure_t   s2_data_next;
    logic        s2_ready;

    logic [26:0] hue_prod;

    // A stage can take new data when it is empty or its content moves on.
    assign s2_ready    = !s2_valid_reg || mid_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign in_ch.ready = s1_ready;

    // Stage 1: scale and round the hue onto the hexcone.
    always_comb
    begin
        hue_prod                = 27'(in_ch.hue) * 27'(HEX_STEPS) + HUE_ROUND;
        s1_data_next.step       = hue_prod[26:16];
        s1_data_next.saturation = in_ch.saturation;
        s1_data_next.value      = in_ch.value;
        s1_data_next.white      = in_ch.white_level;
        s1_valid_next           = s1_ready ? in_ch.valid : s1_valid_reg;
    end

    // Stage 2: pick the ramps of the segment that holds the step.
    always_comb
    begin
        s2_data_next.saturation = s1_data_reg.saturation;
        s2_data_next.value      = s1_data_reg.value;
        s2_data_next.white      = s1_data_reg.white;
        if (s1_data_reg.step < SEG_W)
        begin
            s2_data_next.red   = CHAN_FULL;
            s2_data_next.green = s1_data_reg.step[7:0];
            s2_data_next.blue  = CHAN_ZERO;
        end
        else if (s1_data_reg.step < SEG_2)
        begin
            s2_data_next.red   = 8'(SEG_2 - s1_data_reg.step);
            s2_data_next.green = CHAN_FULL;
            s2_data_next.blue  = CHAN_ZERO;
        end
        else if (s1_data_reg.step < SEG_3)
        begin
            s2_data_next.red   = CHAN_ZERO;
            s2_data_next.green = CHAN_FULL;
            s2_data_next.blue  = 8'(s1_data_reg.step - SEG_2);
        end
        else if (s1_data_reg.step < SEG_4)
        begin
            s2_data_next.red   = CHAN_ZERO;
            s2_data_next.green = 8'(SEG_4 - s1_data_reg.step);
            s2_data_next.blue  = CHAN_FULL;
        end
        else if (s1_data_reg.step < SEG_5)
        begin
            s2_data_next.red   = 8'(s1_data_reg.step - SEG_4);
            s2_data_next.green = CHAN_ZERO;
            s2_data_next.blue  = CHAN_FULL;
        end
        else if (s1_data_reg.step < HEX_STEPS)
        begin
            s2_data_next.red   = CHAN_FULL;
            s2_data_next.green = CHAN_ZERO;
            s2_data_next.blue  = 8'(HEX_STEPS - s1_data_reg.step);
        end
        else
        begin
            // The top step wraps around to pure red.
            s2_data_next.red   = CHAN_FULL;
            s2_data_next.green = CHAN_ZERO;
            s2_data_next.blue  = CHAN_ZERO;
        end
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers load only when their stage advances.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_data_reg <= s1_data_next;
        end
        if (s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign mid_valid = s2_valid_reg;
    assign mid_data  = s2_data_reg;

    // A stalled stage 2 keeps its request intact.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !mid_ready |=> s2_valid_reg && $stable(s2_data_reg))
        else $error("hue stage output changed while stalled");

    // Every hexcone color has one full and one empty primary.
    a_s2_hexcone: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |->
            (s2_data_reg.red == CHAN_FULL || s2_data_reg.green == CHAN_FULL ||
             s2_data_reg.blue == CHAN_FULL) &&
            (s2_data_reg.red == CHAN_ZERO || s2_data_reg.green == CHAN_ZERO ||
             s2_data_reg.blue == CHAN_ZERO))
        else $error("pure color lacks a full or an empty primary");

    // Back pressure reaches the input only when stages 1 and 2 are both occupied.
    a_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && s2_valid_reg)
        else $error("input stalled with an empty pipeline stage");

endmodule

// ===== rtl/hsvrgbw_scale_stage.sv =====
// ----------------------------------------------------------------------------
// hsvrgbw_scale_stage
// Last two pipeline stages: blends each primary toward white by the
// saturation, then scales it by the value. Stage 4 is the output register.
// ----------------------------------------------------------------------------
module hsvrgbw_scale_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mid_valid,
    output logic                   mid_ready,
    input  hsvrgbw_pkg::rgb_pure_t mid_data,
    hsvrgbw_out_if.source          out_ch
);
    import hsvrgbw_pkg::*;

    logic       s3_valid_reg;
    logic       s3_valid_next;
    rgb_sat_t   s3_data_reg;
    rgb_sat_t   s3_data_next;
    logic       s3_ready;

    logic       s4_valid_reg;
    logic       s4_valid_next;
    logic [7:0] s4_red_reg;
    logic [7:0] s4_green_reg;
    logic [7:0] s4_blue_reg;
    logic [7:0] s4_white_reg;
    logic [7:0] s4_red_next;
    logic [7:0] s4_green_next;
    logic [7:0] s4_blue_next;
    logic       s4_ready;

    logic [7:0] sat_floor;

    assign s4_ready  = !s4_valid_reg || out_ch.ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign mid_ready = s3_ready;

    // Stage 3: saturation blend. The scaled part stays at or below the
    // saturation, so adding the grey floor never carries past 8 bits.
    always_comb
    begin
        sat_floor          = CHAN_FULL - mid_data.saturation;
        s3_data_next.red   = mul_frac(mid_data.red, mid_data.saturation) + sat_floor;
        s3_data_next.green = mul_frac(mid_data.green, mid_data.saturation) + sat_floor;
        s3_data_next.blue  = mul_frac(mid_data.blue, mid_data.saturation) + sat_floor;
        s3_data_next.value = mid_data.value;
        s3_data_next.white = mid_data.white;
        s3_valid_next      = s3_ready ? mid_valid : s3_valid_reg;
    end

    // Stage 4: value scaling into the output register.
    always_comb
    begin
        s4_red_next   = mul_frac(s3_data_reg.red, s3_data_reg.value);
        s4_green_next = mul_frac(s3_data_reg.green, s3_data_reg.value);
        s4_blue_next  = mul_frac(s3_data_reg.blue, s3_data_reg.value);
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_data_reg <= s3_data_next;
        end
        if (s4_ready)
        begin
            s4_red_reg   <= s4_red_next;
            s4_green_reg <= s4_green_next;
            s4_blue_reg  <= s4_blue_next;
            s4_white_reg <= s3_data_reg.white;
        end
    end

    assign out_ch.valid = s4_valid_reg;
    assign out_ch.red   = s4_red_reg;
    assign out_ch.green = s4_green_reg;
    assign out_ch.blue  = s4_blue_reg;
    assign out_ch.white = s4_white_reg;

    // After the saturation blend no channel lies below the grey floor.
    a_s3_floor: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid && s3_ready |=>
            s3_data_reg.red >= $past(sat_floor) &&
            s3_data_reg.green >= $past(sat_floor) &&
            s3_data_reg.blue >= $past(sat_floor))
        else $error("saturation blend fell below the grey floor");

    // Value scaling never brightens a channel.
    a_s4_dim: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s4_ready |=>
            s4_red_reg <= $past(s3_data_reg.red) &&
            s4_green_reg <= $past(s3_data_reg.green) &&
            s4_blue_reg <= $past(s3_data_reg.blue))
        else $error("value scaling raised a channel");

    // Stage 3 is held whenever the output register is stalled and full.
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s4_ready |=> s3_valid_reg && $stable(s3_data_reg))
        else $error("saturation stage changed while stalled");

endmodule

// ===== rtl/hsv_to_rgbw_color_top.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgbw_color_top
// HSV plus white to RGBW color converter on an 8-bit hexcone.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_ch (hue, saturation, value, white_level) and
//   results leave on out_ch (red, green, blue, white). Both channels use a
//   valid/ready handshake; a request moves on an edge with both high.
//   The pipeline has four register stages: hue rounding (a 16 x 11 bit
//   multiply), segment ramp selection, saturation blend and value scaling
//   (three 8 x 9 bit multiplies each). An accepted request passes through
//   these stages in that order to its result on out_ch, and one request is
//   accepted every cycle in steady state while out_ch.ready stays high.
//   Each stage holds a valid bit and advances when it is empty or its
//   content moves on, so a receiver stall freezes the full stages behind
//   the output register while empty stages keep filling; in_ch.ready drops
//   only once all four stages hold requests. Nothing is lost or repeated.
//   Reset clears all valid bits; the block is ready in the first cycle
//   after reset is released. There is no configuration and no state
//   carried between requests.
// ----------------------------------------------------------------------------
module hsv_to_rgbw_color_top (
    input  logic          clk,
    input  logic          rst_n,
    hsvrgbw_in_if.sink    in_ch,
    hsvrgbw_out_if.source out_ch
);
    import hsvrgbw_pkg::*;

    logic      mid_valid;
    logic      mid_ready;
    rgb_pure_t mid_data;

    // Hue to pure primaries.
    hsvrgbw_hue_stage u_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data)
    );

    // Saturation and value scaling.
    hsvrgbw_scale_stage u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_data  (mid_data),
        .out_ch    (out_ch)
    );

endmodule
